### src/afp_pkg.sv
// afp_pkg: shared types and constants for the advertisement frame parser.
// No dependencies; imported by every module under src.
`default_nettype none

package afp_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [3:0] HdrLen    = 4'd8;
  localparam logic [7:0] VerMask   = 8'hE0;
  localparam logic [7:0] SockMask  = 8'h1C;
  localparam int unsigned VerShift  = 5;
  localparam int unsigned SockShift = 2;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BADVER   = 3'd2,
    ST_BADSOCK  = 3'd3,
    ST_DSHORT   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_VERSION_MIN  = 2'd0,
    REG_VERSION_MAX  = 2'd1,
    REG_SOCKET_MIN   = 2'd2,
    REG_SOCKET_MAX   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        last;
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [31:0] stated_size;
    logic [23:0] service_hash;
    logic [2:0]  sock_ver;
    logic [2:0]  version;
    logic [1:0]  kind;
  } result_t;

  // Up to two results per accepted byte; slot 1 is only used with slot 0.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

`default_nettype wire

### src/adv_frame_parser.sv
// adv_frame_parser: top level of the advertisement frame parser.
// Depends on afp_pkg, afp_parser and afp_out_queue.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata = in_byte, tlast = frame_end
//  m_axis    out  tvalid/tready           tdata = header/data/status fields,
//                                         tuser = kind, tlast = last
//  cfg       in   cfg_we_i                cfg_idx_i selects register, cfg_data_i
//
// One input word per cycle; each word is parsed in the cycle it is accepted and
// its zero to two results land in a Depth-entry queue (default 4), from which
// m_axis offers them in order.
// Results leave at one per cycle while m_axis_tready is high; s_axis_tready
// drops only when the queue has fewer than two free entries: under output
// stall, or when two-result words come faster than the queue drains.
// Reset clears the header index, data count, header fields and the queue and
// loads version limits 1..2 for both version checks.
`default_nettype none

module adv_frame_parser
  import afp_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [2:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] version, [5:3] sock_ver, [29:6] service_hash,
  // [61:30] stated_size, [69:62] data_byte, [72:70] status, [79:73] zero
  output logic [79:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast
);

  push_t   push;
  result_t res;
  logic    space2;
  logic    in_fire;

  assign s_axis_tready = space2;
  assign in_fire       = s_axis_tvalid && space2;

  afp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (in_fire),
    .byte_i      (s_axis_tdata),
    .frame_end_i (s_axis_tlast),
    .push_o      (push)
  );

  afp_out_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .space2_o (space2),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (res)
  );

  assign m_axis_tdata = {7'd0, res.status, res.data_byte, res.stated_size,
                         res.service_hash, res.sock_ver, res.version};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

### src/afp_parser.sv
// afp_parser: header/data state and per-byte result formation.
// Depends on afp_pkg; feeds the result queue in afp_out_queue.
`default_nettype none

module afp_parser
  import afp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [2:0] cfg_data_i,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       frame_end_i,
  output push_t           push_o
);

  logic [2:0]  ver_min_q, ver_max_q, sock_min_q, sock_max_q;
  logic [3:0]  hi_q, hi_d, hi_n;
  logic [2:0]  ver_q, ver_d, sock_q, sock_d;
  logic [23:0] hash_q, hash_d;
  logic [31:0] size_q, size_d;
  logic [31:0] cnt_q, cnt_d, cnt_n;
  logic        hdr_phase, has_hdr, has_data;
  status_e     st;
  result_t     res_a, res_s;

  always_comb begin
    hdr_phase = (hi_q < HdrLen);
    ver_d     = ver_q;
    sock_d    = sock_q;
    hash_d    = hash_q;
    size_d    = size_q;
    hi_n      = hi_q;
    cnt_n     = cnt_q;
    has_hdr   = 1'b0;
    has_data  = 1'b0;
    if (hdr_phase) begin
      if (hi_q == 4'd0) begin
        ver_d  = 3'((byte_i & VerMask) >> VerShift);
        sock_d = 3'((byte_i & SockMask) >> SockShift);
      end else if (hi_q <= 4'd3) begin
        hash_d = {hash_q[15:0], byte_i};
      end else begin
        size_d = {size_q[23:0], byte_i};
      end
      hi_n    = hi_q + 4'd1;
      has_hdr = (hi_n == HdrLen);
    end else if (cnt_q < size_q) begin
      has_data = 1'b1;
      cnt_n    = cnt_q + 32'd1;
    end

    // Status from the post-byte state, in priority order.
    if (hi_n < HdrLen) begin
      st = ST_SHORT;
    end else if (ver_d < ver_min_q || ver_d > ver_max_q) begin
      st = ST_BADVER;
    end else if (sock_d < sock_min_q || sock_d > sock_max_q) begin
      st = ST_BADSOCK;
    end else if (cnt_n < size_d) begin
      st = ST_DSHORT;
    end else begin
      st = ST_OK;
    end

    hi_d  = frame_end_i ? 4'd0 : hi_n;
    cnt_d = frame_end_i ? 32'd0 : cnt_n;

    res_a = '0;
    if (has_hdr) begin
      res_a.kind         = KIND_HEADER;
      res_a.version      = ver_d;
      res_a.sock_ver     = sock_d;
      res_a.service_hash = hash_d;
      res_a.stated_size  = size_d;
    end else begin
      res_a.kind         = KIND_DATA;
      res_a.data_byte    = byte_i;
    end
    res_a.last = !frame_end_i;

    res_s        = '0;
    res_s.kind   = KIND_STATUS;
    res_s.status = st;
    res_s.last   = 1'b1;

    push_o = '0;
    if (fire_i) begin
      if (has_hdr || has_data) begin
        push_o.v0 = 1'b1;
        push_o.r0 = res_a;
        push_o.v1 = frame_end_i;
        push_o.r1 = res_s;
      end else begin
        push_o.v0 = frame_end_i;
        push_o.r0 = res_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_min_q  <= 3'd1;
      ver_max_q  <= 3'd2;
      sock_min_q <= 3'd1;
      sock_max_q <= 3'd2;
      hi_q       <= '0;
      ver_q      <= '0;
      sock_q     <= '0;
      hash_q     <= '0;
      size_q     <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_VERSION_MIN: ver_min_q  <= cfg_data_i;
          REG_VERSION_MAX: ver_max_q  <= cfg_data_i;
          REG_SOCKET_MIN:  sock_min_q <= cfg_data_i;
          REG_SOCKET_MAX:  sock_max_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire_i) begin
        hi_q   <= hi_d;
        ver_q  <= ver_d;
        sock_q <= sock_d;
        hash_q <= hash_d;
        size_q <= size_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  a_hi_range: assert property (@(posedge clk_i) disable iff (!rst_ni) hi_q <= HdrLen)
    else $error("header index out of range");
  a_cnt_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= size_q)
    else $error("data count passed stated size");
  a_cnt_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hi_q < HdrLen) |-> (cnt_q == 32'd0))
    else $error("data count nonzero during header");

endmodule

`default_nettype wire

### src/afp_out_queue.sv
// afp_out_queue: small result queue, up to two writes and one read per cycle.
// Depends on afp_pkg; its free space sets the input ready.
`default_nettype none

module afp_out_queue
  import afp_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  push_t     push_i,
  output logic      space2_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output result_t   data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [CntW-1:0] CntHigh = CntW'(Depth - 2);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, wr1, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    pop      = valid_o && ready_i;
    wr1      = ptr_inc(wr_q);
    wr_d     = wr_q;
    if (push_i.v1) begin
      wr_d = ptr_inc(wr1);
    end else if (push_i.v0) begin
      wr_d = wr1;
    end
    rd_d     = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d    = cnt_q + CntW'(push_i.v0) + CntW'(push_i.v1) - CntW'(pop);
    space2_o = (cnt_q <= CntHigh);
    valid_o  = (cnt_q != '0);
    data_o   = mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr1] <= push_i.r1;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntFull)
    else $error("queue overfilled");
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v1 |-> push_i.v0)
    else $error("second slot written without first");
  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i.v0) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("queue count lost track on pop");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v0 |-> $past(1'b1) && (cnt_q <= CntHigh))
    else $error("push without room for two words");

endmodule

`default_nettype wire

### sim/afp_checker.sv
// afp_checker: watches the input, output and register ports of adv_frame_parser,
// predicts every result word and compares it with what leaves the block.
// Depends on afp_pkg for the result layout, kind, status and register codes.
`timescale 1ns / 1ps

module afp_checker
  import afp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [2:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] version, [5:3] sock_ver, [29:6] service_hash,
  // [61:30] stated_size, [69:62] data_byte, [72:70] status, [79:73] zero
  input  wire logic [79:0] m_axis_tdata,
  input  wire logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  wire logic        m_axis_tlast,
  output int               mismatch_cnt_o,
  output int               outstanding_o
);

  // parser state as the block should hold it
  logic [3:0]  hdr_idx;
  logic [2:0]  ver_q;
  logic [2:0]  sock_q;
  logic [23:0] hash_q;
  logic [31:0] size_q;
  logic [31:0] dcount_q;

  // acceptance limits
  logic [2:0]  ver_lo, ver_hi, sock_lo, sock_hi;

  result_t     pending_results [$];
  int          mismatch_cnt = 0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Advance the parser by one byte and queue the zero to two results it yields.
  task automatic parse_byte(input logic [7:0] b, input logic fend);
    result_t slot [2];
    result_t r;
    status_e st;
    int      n;
    n = 0;
    if (hdr_idx < HdrLen) begin
      if (hdr_idx == 4'd0) begin
        ver_q  = 3'((b & VerMask) >> VerShift);
        sock_q = 3'((b & SockMask) >> SockShift);
      end else if (hdr_idx <= 4'd3) begin
        hash_q = {hash_q[15:0], b};
      end else begin
        size_q = {size_q[23:0], b};
      end
      hdr_idx = hdr_idx + 4'd1;
      if (hdr_idx == HdrLen) begin
        r              = '0;
        r.kind         = KIND_HEADER;
        r.version      = ver_q;
        r.sock_ver     = sock_q;
        r.service_hash = hash_q;
        r.stated_size  = size_q;
        slot[n]        = r;
        n++;
      end
    end else if (dcount_q < size_q) begin
      r           = '0;
      r.kind      = KIND_DATA;
      r.data_byte = b;
      slot[n]     = r;
      n++;
      dcount_q    = dcount_q + 32'd1;
    end
    if (fend) begin
      // fault priority: too short, version, socket version, missing data
      if (hdr_idx < HdrLen)                         st = ST_SHORT;
      else if (ver_q < ver_lo || ver_q > ver_hi)    st = ST_BADVER;
      else if (sock_q < sock_lo || sock_q > sock_hi) st = ST_BADSOCK;
      else if (dcount_q < size_q)                   st = ST_DSHORT;
      else                                          st = ST_OK;
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = st;
      slot[n]  = r;
      n++;
      hdr_idx  = '0;
      dcount_q = '0;
    end
    if (n > 0) slot[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(slot[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      hdr_idx  = '0;
      ver_q    = '0;
      sock_q   = '0;
      hash_q   = '0;
      size_q   = '0;
      dcount_q = '0;
      ver_lo   = 3'd1;
      ver_hi   = 3'd2;
      sock_lo  = 3'd1;
      sock_hi  = 3'd2;
      pending_results.delete();
    end else begin
      // outputs at this edge stem from earlier words, so compare first
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: tuser 0x%0h tdata 0x%0h",
                 m_axis_tuser, m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
          check_field("version", 32'(want.version), 32'(m_axis_tdata[2:0]));
          check_field("sock_ver", 32'(want.sock_ver), 32'(m_axis_tdata[5:3]));
          check_field("service_hash", 32'(want.service_hash),
                      32'(m_axis_tdata[29:6]));
          check_field("stated_size", want.stated_size, m_axis_tdata[61:30]);
          check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[69:62]));
          check_field("status", 32'(want.status), 32'(m_axis_tdata[72:70]));
          check_field("last", 32'(want.last), 32'(m_axis_tlast));
          check_field("padding", 32'd0, 32'(m_axis_tdata[79:73]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_VERSION_MIN: ver_lo  = cfg_data_i;
          REG_VERSION_MAX: ver_hi  = cfg_data_i;
          REG_SOCKET_MIN:  sock_lo = cfg_data_i;
          REG_SOCKET_MAX:  sock_hi = cfg_data_i;
          default: ;
        endcase
      end
    end
    outstanding_o  = pending_results.size();
    mismatch_cnt_o = mismatch_cnt;
  end

endmodule

### sim/tb_top.sv
// tb_top: stimulus and verdict for adv_frame_parser; frames go in as byte words
// with bursty gaps, the result side stalls on its own pattern.
// Depends on afp_pkg, adv_frame_parser and afp_checker.
`timescale 1ns / 1ps

module tb_top;
  import afp_pkg::*;

  localparam int TotalWords = 1600;
  localparam int Directed   = 28;
  localparam int Phases     = 6;
  localparam int HoldCycles = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [2:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int          mismatch_cnt;
  int          outstanding;
  int          words_sent = 0;
  int          burst_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  logic [2:0]  lim_v_lo = 3'd1, lim_v_hi = 3'd2, lim_s_lo = 3'd1, lim_s_hi = 3'd2;
  logic [7:0]  frame_bytes [$];

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  adv_frame_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  afp_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid  (s_tvalid),
    .s_axis_tready  (s_tready),
    .s_axis_tdata   (s_tdata),
    .s_axis_tlast   (s_tlast),
    .m_axis_tvalid  (m_tvalid),
    .m_axis_tready  (m_tready),
    .m_axis_tdata   (m_tdata),
    .m_axis_tuser   (m_tuser),
    .m_axis_tlast   (m_tlast),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  // Offer one word; called at a falling edge, returns at a falling edge.
  task automatic send_word(input logic [7:0] b, input logic fend);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      // now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fend;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    words_sent++;
    burst_left--;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_word(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  task automatic push_header(input logic [2:0] ver, input logic [2:0] sock,
                             input logic [23:0] hash, input logic [31:0] size);
    frame_bytes.push_back({ver, sock, 2'($urandom)});
    frame_bytes.push_back(hash[23:16]);
    frame_bytes.push_back(hash[15:8]);
    frame_bytes.push_back(hash[7:0]);
    frame_bytes.push_back(size[31:24]);
    frame_bytes.push_back(size[23:16]);
    frame_bytes.push_back(size[15:8]);
    frame_bytes.push_back(size[7:0]);
  endtask

  task automatic make_random_frame();
    int          pick;
    int          ndata;
    logic [2:0]  ver, sock;
    logic [31:0] size;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // well-formed header, mostly with accepted versions
      if (lim_v_lo <= lim_v_hi && $urandom_range(0, 3) != 0)
        ver = 3'($urandom_range(lim_v_lo, lim_v_hi));
      else
        ver = 3'($urandom);
      if (lim_s_lo <= lim_s_hi && $urandom_range(0, 3) != 0)
        sock = 3'($urandom_range(lim_s_lo, lim_s_hi));
      else
        sock = 3'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 85)      size = $urandom_range(0, 12);
      else if (pick < 95) size = $urandom_range(13, 40);
      else                size = $urandom;
      if (size > 40) begin
        ndata = $urandom_range(0, 6);
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    ndata = size;
          2:       ndata = (size > 0) ? $urandom_range(0, size - 1) : 0;
          default: ndata = size + $urandom_range(1, 4);
        endcase
      end
      push_header(ver, sock, 24'($urandom), size);
      repeat (ndata) frame_bytes.push_back(8'($urandom));
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 7)) frame_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic write_limits(input logic [2:0] vlo, input logic [2:0] vhi,
                              input logic [2:0] slo, input logic [2:0] shi);
    // drop valid, drain every expected word, let the pipe settle
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_VERSION_MIN;
    cfg_data <= vlo;
    @(negedge clk_i);
    cfg_idx  <= REG_VERSION_MAX;
    cfg_data <= vhi;
    @(negedge clk_i);
    cfg_idx  <= REG_SOCKET_MIN;
    cfg_data <= slo;
    @(negedge clk_i);
    cfg_idx  <= REG_SOCKET_MAX;
    cfg_data <= shi;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    lim_v_lo = vlo;
    lim_v_hi = vhi;
    lim_s_lo = slo;
    lim_s_hi = shi;
  endtask

  // result side: changing stall patterns plus one long hold-off
  initial begin : result_sink
    int         mode;
    int         mode_left;
    int         hold_left;
    logic [7:0] mask;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    mask      = '0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 200);
          mask      = 8'($urandom);
        end
        mode_left--;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            m_tready <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [2:0] lim [4];
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // too short: end on the first byte
    frame_bytes.push_back(8'hFF);
    send_frame();
    // all-ones hash, one data byte, then an excess byte dropped
    push_header(3'd2, 3'd2, 24'hFFFFFF, 32'd1);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h00);
    send_frame();
    // header on the final byte, bad socket version, size all ones
    push_header(3'd1, 3'd7, 24'h000000, 32'hFFFF_FFFF);
    send_frame();
    // bad version outranks missing data
    push_header(3'd0, 3'd1, 24'h5AA55A, 32'd3);
    frame_bytes.push_back(8'h77);
    send_frame();

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: write_limits(3'd1, 3'd2, 3'd1, 3'd2);
        1: write_limits(3'd0, 3'd7, 3'd0, 3'd7);
        2: write_limits(3'd7, 3'd7, 3'd0, 3'd0);
        3: write_limits(3'd5, 3'd2, 3'd6, 3'd1);   // min above max
        4: write_limits(3'd0, 3'd0, 3'd7, 3'd7);
        default: begin
          for (int i = 0; i < 4; i++) lim[i] = 3'($urandom);
          write_limits(lim[0], lim[1], lim[2], lim[3]);
        end
      endcase
      if (ph == 1) hold_req = 1'b1;
      while (words_sent < Directed + (ph + 1) * (TotalWords - Directed) / Phases) begin
        make_random_frame();
        send_frame();
      end
    end

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("adv_frame_parser test passed");
    end else begin
      $display("adv_frame_parser test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("adv_frame_parser test failed");
    $finish;
  end

endmodule
